FILE: design/m3inv_pkg.sv
package m3inv_pkg;

  localparam int DataW      = 32;
  localparam int Lanes      = 9;
  localparam int CofW       = 2 * DataW + 1;
  localparam int CMagW      = 2 * DataW;
  localparam int DetW       = 3 * DataW + 1;
  localparam int MagW       = 3 * DataW;
  localparam int FrontDepth = 7;
  localparam int DivSteps   = DataW;
  localparam int Latency    = FrontDepth + DivSteps + 1;

  localparam logic [DataW-1:0] SatPos = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] SatNeg = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    logic signed [DataW-1:0] m00;
    logic signed [DataW-1:0] m01;
    logic signed [DataW-1:0] m02;
    logic signed [DataW-1:0] m10;
    logic signed [DataW-1:0] m11;
    logic signed [DataW-1:0] m12;
    logic signed [DataW-1:0] m20;
    logic signed [DataW-1:0] m21;
    logic signed [DataW-1:0] m22;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] r00;
    logic signed [DataW-1:0] r01;
    logic signed [DataW-1:0] r02;
    logic signed [DataW-1:0] r10;
    logic signed [DataW-1:0] r11;
    logic signed [DataW-1:0] r12;
    logic signed [DataW-1:0] r20;
    logic signed [DataW-1:0] r21;
    logic signed [DataW-1:0] r22;
    logic                    singular;
    logic                    overflow;
  } out_word_t;

  // lane k = 3*row + col of the result; rem holds the partial remainder
  typedef struct packed {
    in_word_t                       mat;
    logic [Lanes-1:0][MagW-1:0]     rem;
    logic [Lanes-1:0][DataW-1:0]    quo;
    logic [Lanes-1:0]               neg;
    logic [Lanes-1:0]               pre_ovf;
    logic [MagW-1:0]                dmag;
    logic                           dz;
  } div_word_t;

endpackage

FILE: design/matrix3_inverse.sv
// Throughput: one matrix per cycle while busy is low; 7 front stages (cofactors, determinant),
// 32 divider stages (one quotient bit per stage in 9 lanes), 1 output stage.
// busy is high only while rst_ni is low; done_o strobes each result for one cycle.
// Reset clears the valid bits only; words in flight at reset are dropped.
module matrix3_inverse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  m3inv_pkg::in_word_t   in_i,
  output logic                  done_o,
  output m3inv_pkg::out_word_t  out_o
);
  import m3inv_pkg::*;

  logic             div_vld  [DivSteps+1];
  div_word_t        div_word [DivSteps+1];
  logic [DataW-1:0] res [Lanes];
  logic [Lanes-1:0] ovf;
  div_word_t        fin;
  logic             done_q;
  out_word_t        out_d;
  out_word_t        out_q;

  assign busy = ~rst_ni;

  m3inv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .in_i    (in_i),
    .valid_o (div_vld[0]),
    .word_o  (div_word[0])
  );

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    m3inv_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_vld[s]),
      .word_i  (div_word[s]),
      .valid_o (div_vld[s+1]),
      .word_o  (div_word[s+1])
    );
  end

  assign fin = div_word[DivSteps];

  // saturate to Q16.16, apply sign
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      ovf[k] = fin.pre_ovf[k] |
               (fin.quo[k][DataW-1] & (~fin.neg[k] | (|fin.quo[k][DataW-2:0])));
      res[k] = ovf[k] ? (fin.neg[k] ? SatNeg : SatPos) : fin.quo[k];
      if (fin.neg[k]) begin
        res[k] = '0 - res[k];
      end
    end
  end

  always_comb begin
    if (fin.dz) begin
      out_d.r00 = fin.mat.m00;
      out_d.r01 = fin.mat.m01;
      out_d.r02 = fin.mat.m02;
      out_d.r10 = fin.mat.m10;
      out_d.r11 = fin.mat.m11;
      out_d.r12 = fin.mat.m12;
      out_d.r20 = fin.mat.m20;
      out_d.r21 = fin.mat.m21;
      out_d.r22 = fin.mat.m22;
    end else begin
      out_d.r00 = $signed(res[0]);
      out_d.r01 = $signed(res[1]);
      out_d.r02 = $signed(res[2]);
      out_d.r10 = $signed(res[3]);
      out_d.r11 = $signed(res[4]);
      out_d.r12 = $signed(res[5]);
      out_d.r20 = $signed(res[6]);
      out_d.r21 = $signed(res[7]);
      out_d.r22 = $signed(res[8]);
    end
    out_d.singular = fin.dz;
    out_d.overflow = ~fin.dz & (|ovf);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_vld[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without an accepted word");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.singular) |-> !out_o.overflow)
    else $error("singular result flagged overflow");
`endif

endmodule

FILE: design/m3inv_front.sv
module m3inv_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  m3inv_pkg::in_word_t   in_i,
  output logic                  valid_o,
  output m3inv_pkg::div_word_t  word_o
);
  import m3inv_pkg::*;

  localparam int LoW = DataW + 1;
  localparam int HiW = CofW - LoW;
  localparam int PlW = DataW + LoW + 1;
  localparam int PhW = DataW + HiW;
  localparam int PrW = 2 * DataW;

  function automatic logic signed [PrW-1:0] smul(input logic signed [DataW-1:0] x,
                                                 input logic signed [DataW-1:0] y);
    return PrW'(x) * PrW'(y);
  endfunction

  logic [FrontDepth-1:0]   vld_q;
  in_word_t                mat_q [FrontDepth-1];
  logic signed [DataW-1:0] a   [3][3];
  logic signed [DataW-1:0] m0  [3];

  logic signed [PrW-1:0]   pp_d [3][3];
  logic signed [PrW-1:0]   pp_q [3][3];
  logic signed [PrW-1:0]   ps_d [3][3];
  logic signed [PrW-1:0]   ps_q [3][3];
  logic signed [CofW-1:0]  cof2_d [3][3];
  logic signed [CofW-1:0]  cof2_q [3][3];
  logic signed [CofW-1:0]  cof3_q [3][3];
  logic signed [CofW-1:0]  cof4_q [3][3];
  logic signed [CofW-1:0]  cof5_q [3][3];
  logic signed [PlW-1:0]   pl_d [3];
  logic signed [PlW-1:0]   pl_q [3];
  logic signed [PhW-1:0]   ph_d [3];
  logic signed [PhW-1:0]   ph_q [3];
  logic signed [DetW-1:0]  term_d [3];
  logic signed [DetW-1:0]  term_q [3];
  logic signed [DetW-1:0]  det_d;
  logic signed [DetW-1:0]  det_q;
  logic signed [DetW-1:0]  det_neg;
  logic [MagW-1:0]         dmag_d;
  logic [MagW-1:0]         dmag_q;
  logic                    dz_d;
  logic                    dz_q;
  logic [CMagW-1:0]        cmag_d [Lanes];
  logic [CMagW-1:0]        cmag_q [Lanes];
  logic [Lanes-1:0]        neg_d;
  logic [Lanes-1:0]        neg_q;
  div_word_t               word_d;
  div_word_t               word_q;

  always_comb begin
    a[0][0] = in_i.m00;
    a[0][1] = in_i.m01;
    a[0][2] = in_i.m02;
    a[1][0] = in_i.m10;
    a[1][1] = in_i.m11;
    a[1][2] = in_i.m12;
    a[2][0] = in_i.m20;
    a[2][1] = in_i.m21;
    a[2][2] = in_i.m22;
    m0[0]   = mat_q[1].m00;
    m0[1]   = mat_q[1].m01;
    m0[2]   = mat_q[1].m02;
  end

  // stage 1: minor products, stage 2: cofactors
  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      localparam int I1 = (gi + 1) % 3;
      localparam int I2 = (gi + 2) % 3;
      localparam int J1 = (gj + 1) % 3;
      localparam int J2 = (gj + 2) % 3;
      logic signed [CofW-1:0] cneg;
      assign pp_d[gi][gj]   = smul(a[I1][J1], a[I2][J2]);
      assign ps_d[gi][gj]   = smul(a[I1][J2], a[I2][J1]);
      assign cof2_d[gi][gj] = CofW'(pp_q[gi][gj]) - CofW'(ps_q[gi][gj]);
      // stage 6 lane for result (gi, gj) uses cofactor (gj, gi)
      assign cneg = -cof5_q[gj][gi];
      assign cmag_d[gi*3+gj] = cof5_q[gj][gi][CofW-1] ? cneg[CMagW-1:0]
                                                       : cof5_q[gj][gi][CMagW-1:0];
      assign neg_d[gi*3+gj]  = cof5_q[gj][gi][CofW-1] ^ det_q[DetW-1];
    end
  end

  // stage 3: row-0 products split in two, stage 4: recombine, stage 5: sum
  for (genvar gj = 0; gj < 3; gj++) begin : g_det
    logic signed [LoW:0] lo_ext;
    assign lo_ext     = $signed({1'b0, cof2_q[0][gj][LoW-1:0]});
    assign pl_d[gj]   = PlW'(m0[gj]) * PlW'(lo_ext);
    assign ph_d[gj]   = PhW'(m0[gj]) * PhW'($signed(cof2_q[0][gj][CofW-1:LoW]));
    assign term_d[gj] = (DetW'(ph_q[gj]) <<< LoW) + DetW'(pl_q[gj]);
  end

  assign det_d   = term_q[0] + term_q[1] + term_q[2];
  assign det_neg = -det_q;
  assign dmag_d  = det_q[DetW-1] ? det_neg[MagW-1:0] : det_q[MagW-1:0];
  assign dz_d    = (det_q == '0);

  // stage 7: divider setup
  always_comb begin
    word_d.mat  = mat_q[FrontDepth-2];
    word_d.quo  = '0;
    word_d.neg  = neg_q;
    word_d.dmag = dmag_q;
    word_d.dz   = dz_q;
    for (int k = 0; k < Lanes; k++) begin
      word_d.rem[k]     = MagW'(cmag_q[k]);
      word_d.pre_ovf[k] = (MagW'(cmag_q[k]) >= dmag_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FrontDepth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mat_q[0] <= in_i;
    for (int s = 1; s < FrontDepth - 1; s++) begin
      mat_q[s] <= mat_q[s-1];
    end
    pp_q   <= pp_d;
    ps_q   <= ps_d;
    cof2_q <= cof2_d;
    cof3_q <= cof2_q;
    cof4_q <= cof3_q;
    cof5_q <= cof4_q;
    pl_q   <= pl_d;
    ph_q   <= ph_d;
    term_q <= term_d;
    det_q  <= det_d;
    dmag_q <= dmag_d;
    dz_q   <= dz_d;
    cmag_q <= cmag_d;
    neg_q  <= neg_d;
    word_q <= word_d;
  end

  assign valid_o = vld_q[FrontDepth-1];
  assign word_o  = word_q;

endmodule

FILE: design/m3inv_div_step.sv
module m3inv_div_step (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  m3inv_pkg::div_word_t  word_i,
  output logic                  valid_o,
  output m3inv_pkg::div_word_t  word_o
);
  import m3inv_pkg::*;

  logic [MagW:0]    r2   [Lanes];
  logic [MagW:0]    diff [Lanes];
  logic [Lanes-1:0] ge;
  logic             valid_q;
  div_word_t        word_d;
  div_word_t        word_q;

  // one restoring step per lane: shift, compare, subtract
  always_comb begin
    word_d = word_i;
    for (int k = 0; k < Lanes; k++) begin
      r2[k]         = {word_i.rem[k], 1'b0};
      diff[k]       = r2[k] - {1'b0, word_i.dmag};
      ge[k]         = (r2[k] >= {1'b0, word_i.dmag});
      word_d.rem[k] = ge[k] ? diff[k][MagW-1:0] : r2[k][MagW-1:0];
      word_d.quo[k] = {word_i.quo[k][DataW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

import m3inv_pkg::*;

class inverse_scoreboard;
  out_word_t expected_inverses[$];
  int        mismatches;
  int        words_checked;
  string     field_name[11];

  function new();
    field_name = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22",
                   "singular", "overflow"};
    mismatches    = 0;
    words_checked = 0;
  endfunction

  // adjugate over determinant; all products kept exact in 128 bits
  function out_word_t predict_inverse(in_word_t m);
    logic signed [127:0] a [9];
    logic signed [127:0] cof [9];
    logic signed [127:0] det, c;
    logic [127:0]        dmag, num, quo, lim;
    logic [31:0]         ent [9];
    logic                neg, sat;
    int                  i, j, i1, i2, j1, j2, k;
    a[0] = $signed(m.m00); a[1] = $signed(m.m01); a[2] = $signed(m.m02);
    a[3] = $signed(m.m10); a[4] = $signed(m.m11); a[5] = $signed(m.m12);
    a[6] = $signed(m.m20); a[7] = $signed(m.m21); a[8] = $signed(m.m22);
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        i1 = (i + 1) % 3; i2 = (i + 2) % 3;
        j1 = (j + 1) % 3; j2 = (j + 2) % 3;
        cof[3*i+j] = a[3*i1+j1] * a[3*i2+j2] - a[3*i1+j2] * a[3*i2+j1];
      end
    end
    det = a[0] * cof[0] + a[1] * cof[1] + a[2] * cof[2];
    if (det == 0) begin
      return {m, 1'b1, 1'b0};
    end
    dmag = (det < 0) ? -det : det;
    sat  = 1'b0;
    for (k = 0; k < 9; k++) begin
      i   = k / 3;
      j   = k % 3;
      c   = cof[3*j+i];
      neg = (c < 0) != (det < 0);
      num = ((c < 0) ? -c : c) << 32;
      quo = num / dmag;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (quo > lim) begin
        sat = 1'b1;
        quo = lim;
      end
      if (neg) begin
        quo = -quo;
      end
      ent[k] = quo[31:0];
    end
    return {ent[0], ent[1], ent[2], ent[3], ent[4], ent[5], ent[6], ent[7], ent[8],
            1'b0, sat};
  endfunction

  function void note_matrix(in_word_t m);
    expected_inverses.push_back(predict_inverse(m));
  endfunction

  function void check_inverse(out_word_t got);
    out_word_t    want;
    logic [289:0] eb, gb;
    logic [31:0]  e, g;
    int           k;
    if (expected_inverses.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected word: %h", got);
      end
      return;
    end
    want = expected_inverses.pop_front();
    eb   = want;
    gb   = got;
    for (k = 0; k < 11; k++) begin
      if (k < 9) begin
        e = eb[289-32*k -: 32];
        g = gb[289-32*k -: 32];
      end else begin
        e = eb[10-k];
        g = gb[10-k];
      end
      if (e !== g) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("word %0d %s: expected %h got %h", words_checked, field_name[k], e, g);
        end
      end
    end
    words_checked++;
  endfunction

  function int pending();
    return expected_inverses.size();
  endfunction
endclass

module tb;
  localparam int StallLimit = 1000;
  localparam int ItemsPerPhase = 234;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_i = '0;
  logic      done_o;
  out_word_t out_o;

  inverse_scoreboard sb = new();
  int                stall_cycles = 0;
  int                idle_pct [3] = '{0, 66, 15};
  in_word_t          directed_q[$];

  matrix3_inverse uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .done_o (done_o),
    .out_o  (out_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        sb.note_matrix(in_i);
      end
      if (done_o) begin
        sb.check_inverse(out_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  function automatic logic [31:0] fx(int n);
    return n << 16;
  endfunction

  function automatic in_word_t random_matrix();
    logic [31:0] v [9];
    int          kind, span, k, t;
    kind = $urandom_range(0, 9);
    span = 1 << $urandom_range(12, 20);
    for (k = 0; k < 9; k++) begin
      case (kind)
        0, 1: begin
          v[k] = $urandom();
        end
        2, 3, 4: begin
          t    = $urandom_range(0, 2 * span);
          v[k] = t - span;
        end
        5: begin
          t    = $urandom_range(0, 6);
          v[k] = fx(t - 3);
        end
        6: begin
          t    = $urandom_range(0, 2 * span);
          v[k] = (k < 6) ? t - span : v[k-6] - v[k-3];
        end
        7: begin
          t    = $urandom_range(0, 511);
          v[k] = t - 256;
        end
        8: begin
          case ($urandom_range(0, 5))
            0: v[k] = SatPos;
            1: v[k] = SatNeg;
            2: v[k] = '0;
            3: v[k] = 32'd1;
            4: v[k] = '1;
            default: v[k] = $urandom();
          endcase
        end
        default: begin
          v[k] = $urandom_range(0, 1) ? $urandom() : '0;
        end
      endcase
    end
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
  endfunction

  task automatic send_matrix(in_word_t w, int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_i  <= w;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    int p, n;
    directed_q.push_back('{fx(1), 0, 0, 0, fx(1), 0, 0, 0, fx(1)});
    directed_q.push_back('0);
    directed_q.push_back('{SatPos, SatPos, SatPos, SatPos, SatPos, SatPos,
                           SatPos, SatPos, SatPos});
    directed_q.push_back('{SatNeg, SatNeg, SatNeg, SatNeg, SatNeg, SatNeg,
                           SatNeg, SatNeg, SatNeg});
    directed_q.push_back('1);
    directed_q.push_back('{SatNeg, 0, 0, 0, SatNeg, 0, 0, 0, SatNeg});
    directed_q.push_back('{SatPos, 0, 0, 0, SatPos, 0, 0, 0, SatPos});
    directed_q.push_back('{1, 0, 0, 0, 1, 0, 0, 0, 1});
    directed_q.push_back('{-1, 0, 0, 0, -1, 0, 0, 0, -1});
    directed_q.push_back('{-2, 0, 0, 0, -2, 0, 0, 0, -2});
    directed_q.push_back('{2, 0, 0, 0, 2, 0, 0, 0, 2});
    directed_q.push_back('{fx(1), fx(2), fx(3), 0, fx(1), fx(4), fx(5), fx(6), 0});
    directed_q.push_back('{fx(1), fx(2), fx(3), fx(4), fx(5), fx(6), fx(7), fx(8), fx(9)});
    directed_q.push_back('{0, fx(1), 0, 0, 0, fx(1), fx(1), 0, 0});
    directed_q.push_back('{0, 0, fx(-1), fx(-1), 0, 0, 0, fx(-1), 0});
    directed_q.push_back('{fx(2), 0, 0, 0, 32'h8000, 0, 0, 0, fx(-4)});
    directed_q.push_back('{SatPos, SatNeg, 0, SatNeg, SatPos, 1, 0, 1, SatPos});
    directed_q.push_back('{SatNeg, SatPos, SatPos, SatPos, SatNeg, SatPos,
                           SatPos, SatPos, SatNeg});
    directed_q.push_back('{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                           32'h55555555, 32'haaaaaaaa, 32'h55555555,
                           32'h0f0f0f0f, 32'hf0f0f0f0, 32'h33333333});
    directed_q.push_back('{fx(1), fx(1), fx(1), 0, fx(1), fx(1), 0, 0, fx(1)});
    directed_q.push_back('{1, 0, 0, 0, fx(1), 0, 0, 0, fx(1)});
    directed_q.push_back('{fx(3), fx(-2), fx(5), fx(6), fx(-4), fx(10), fx(1), fx(7), fx(-3)});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[n]) begin
      send_matrix(directed_q[n], 0);
    end
    for (p = 0; p < 3; p++) begin
      for (n = 0; n < ItemsPerPhase; n++) begin
        send_matrix(random_matrix(), idle_pct[p]);
      end
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
design/m3inv_pkg.sv
design/m3inv_front.sv
design/m3inv_div_step.sv
design/matrix3_inverse.sv
test/tb.sv
